[hdl/i2cm_pkg.sv]
// Shared types and constants for the I2C master line sequencer.
package i2cm_pkg;

    localparam int BITS_PER_BYTE       = 8;
    localparam int I2CM_QUEUE_DEPTH    = 2;
    localparam int CFG_WIDTH           = 16;
    localparam logic [15:0] PHASE_TICKS_RESET    = 16'd4;
    localparam logic [15:0] ACK_POLL_LIMIT_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic CFG_PHASE_TICKS    = 1'b0;
    localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // One tick request as it travels from the front stage to the sequencer.
    typedef struct packed {
        logic       cmd_valid;
        t_op        operation;
        logic [7:0] tx_byte;
        logic       ack_flag;
        logic       sda_in;
    } t_item;

    // Configuration write as seen by the sequencer.
    typedef struct packed {
        logic                 we;
        logic                 index;
        logic [CFG_WIDTH-1:0] wdata;
    } t_cfg_wr;

endpackage

[hdl/i2cm_front.sv]
// Input stage: registers and unpacks incoming tick requests ahead of the queue.
module i2cm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [15:0]    s_axis_tdata,  // [7:0] tx_byte, [8] ack_flag, [9] sda_in, rest zero
    input  logic [2:0]     s_axis_tuser,  // [0] cmd_valid, [2:1] operation
    output logic           o_push,
    output i2cm_pkg::t_item o_item,
    input  logic           i_queue_ready
);
    import i2cm_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign s_axis_tready = !r_valid || i_queue_ready;
    assign o_push        = r_valid;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.cmd_valid <= s_axis_tuser[0];
            r_item.operation <= t_op'(s_axis_tuser[2:1]);
            r_item.tx_byte   <= s_axis_tdata[7:0];
            r_item.ack_flag  <= s_axis_tdata[8];
            r_item.sda_in    <= s_axis_tdata[9];
        end
    end

endmodule

[hdl/i2cm_queue.sv]
// Short first-word-fall-through queue between the front stage and the sequencer.
module i2cm_queue #(
    parameter int DEPTH = i2cm_pkg::I2CM_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2cm_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output i2cm_pkg::t_item o_item,
    input  logic            i_pop
);
    import i2cm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_do_push;
    logic           w_do_pop;

    assign o_ready   = r_count != CW'(DEPTH);
    assign o_valid   = r_count != '0;
    assign o_item    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hdl/i2cm_engine.sv]
// Line sequencer: steps SCL and SDA through each command, one tick per request.
module i2cm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i2cm_pkg::t_cfg_wr i_cfg,
    input  logic              i_item_valid,
    input  i2cm_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D,
        PH_W_LOW, PH_W_HIGH,
        PH_AK_A, PH_AK_B, PH_AK_C, PH_AK_POLL, PH_AK_D,
        PH_R_A, PH_R_HIGH, PH_R_LOW,
        PH_K_A, PH_K_B, PH_K_C, PH_K_D
    } t_phase;

    logic [15:0] r_phase_ticks, r_ack_poll_limit;
    t_phase      r_phase, n_phase;
    logic [15:0] r_delay, n_delay;
    logic [15:0] r_poll, n_poll;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_sda_en, n_sda_en;
    logic [7:0]  r_rx, n_rx;
    logic        r_ack, n_ack;
    logic        r_tmo, n_tmo;
    logic        r_ack_req, n_ack_req;
    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic        w_step;
    logic        w_done;
    logic [15:0] w_ticks;
    logic [15:0] w_limit;
    logic [3:0]  w_bits_inc;
    logic [15:0] w_poll_dec;
    logic [15:0] w_out;

    assign w_step        = i_item_valid && (!r_out_valid || m_axis_tready);
    assign o_pop         = w_step;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A zero setting behaves as one.
    assign w_ticks    = (r_phase_ticks == '0) ? 16'd1 : r_phase_ticks;
    assign w_limit    = (r_ack_poll_limit == '0) ? 16'd1 : r_ack_poll_limit;
    assign w_bits_inc = r_bits + 4'd1;
    assign w_poll_dec = (r_poll != '0) ? r_poll - 16'd1 : 16'd0;

    always_comb begin
        n_phase   = r_phase;
        n_delay   = r_delay;
        n_poll    = r_poll;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_sda_en  = r_sda_en;
        n_rx      = r_rx;
        n_ack     = r_ack;
        n_tmo     = r_tmo;
        n_ack_req = r_ack_req;
        w_done    = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_item.cmd_valid) begin
                n_delay = w_ticks;
                case (i_item.operation)
                    OP_START: begin
                        n_sda_en = 1'b1;
                        n_scl    = 1'b1;
                        n_phase  = PH_ST_A;
                    end
                    OP_STOP: begin
                        n_sda_en = 1'b1;
                        n_sda    = 1'b0;
                        n_phase  = PH_SP_A;
                    end
                    OP_WRITE: begin
                        n_sda_en  = 1'b1;
                        n_scl     = 1'b0;
                        n_shift   = i_item.tx_byte;
                        n_bits    = '0;
                        n_ack_req = i_item.ack_flag;
                        n_sda     = i_item.tx_byte[7];
                        n_ack     = 1'b0;
                        n_tmo     = 1'b0;
                        n_phase   = PH_W_LOW;
                    end
                    default: begin
                        n_sda_en  = 1'b0;
                        n_scl     = 1'b0;
                        n_shift   = '0;
                        n_bits    = '0;
                        n_ack_req = i_item.ack_flag;
                        n_phase   = PH_R_A;
                    end
                endcase
            end
        end else if (r_phase == PH_AK_POLL) begin
            if (!i_item.sda_in) begin
                n_scl   = 1'b0;
                n_phase = PH_AK_D;
                n_delay = w_ticks;
            end else begin
                n_poll = w_poll_dec;
                if (w_poll_dec == '0) begin
                    // Gave up on the acknowledge: release the bus with a stop.
                    n_tmo    = 1'b1;
                    n_ack    = 1'b0;
                    n_sda_en = 1'b1;
                    n_sda    = 1'b0;
                    n_phase  = PH_SP_A;
                    n_delay  = w_ticks;
                end
            end
        end else if (r_delay <= 16'd1) begin
            n_delay = w_ticks;
            case (r_phase)
                PH_ST_A: begin n_sda = 1'b1; n_phase = PH_ST_B; end
                PH_ST_B: begin n_sda = 1'b0; n_phase = PH_ST_C; end
                PH_ST_C: begin n_scl = 1'b0; n_phase = PH_ST_D; end
                PH_SP_A: begin n_scl = 1'b0; n_phase = PH_SP_B; end
                PH_SP_B: begin n_scl = 1'b1; n_phase = PH_SP_C; end
                PH_SP_C: begin n_sda = 1'b1; n_phase = PH_SP_D; end
                PH_W_LOW: begin n_scl = 1'b1; n_phase = PH_W_HIGH; end
                PH_W_HIGH: begin
                    n_scl   = 1'b0;
                    n_bits  = w_bits_inc;
                    n_shift = {r_shift[6:0], 1'b0};
                    if (w_bits_inc < 4'(BITS_PER_BYTE)) begin
                        n_sda   = r_shift[6];
                        n_phase = PH_W_LOW;
                    end else if (r_ack_req) begin
                        n_sda_en = 1'b0;
                        n_phase  = PH_AK_A;
                    end else begin
                        n_ack   = 1'b1;
                        n_phase = PH_IDLE;
                        n_delay = '0;
                        w_done  = 1'b1;
                    end
                end
                PH_AK_A: begin n_sda = 1'b1; n_phase = PH_AK_B; end
                PH_AK_B: begin n_scl = 1'b1; n_phase = PH_AK_C; end
                PH_AK_C: begin
                    n_poll  = w_limit;
                    n_phase = PH_AK_POLL;
                    n_delay = '0;
                end
                PH_AK_D: begin
                    n_ack   = 1'b1;
                    n_phase = PH_IDLE;
                    n_delay = '0;
                    w_done  = 1'b1;
                end
                PH_R_A: begin n_scl = 1'b1; n_phase = PH_R_HIGH; end
                PH_R_HIGH: begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_bits  = w_bits_inc;
                    n_scl   = 1'b0;
                    n_phase = PH_R_LOW;
                end
                PH_R_LOW: begin
                    if (r_bits < 4'(BITS_PER_BYTE)) begin
                        n_scl   = 1'b1;
                        n_phase = PH_R_HIGH;
                    end else begin
                        n_rx    = r_shift;
                        n_scl   = 1'b0;
                        n_phase = PH_K_A;
                    end
                end
                PH_K_A: begin
                    n_sda_en = 1'b1;
                    n_sda    = !r_ack_req;
                    n_phase  = PH_K_B;
                end
                PH_K_B: begin n_scl = 1'b1; n_phase = PH_K_C; end
                PH_K_C: begin n_scl = 1'b0; n_phase = PH_K_D; end
                default: begin
                    n_phase = PH_IDLE;
                    n_delay = '0;
                    w_done  = 1'b1;
                end
            endcase
        end else begin
            n_delay = r_delay - 16'd1;
        end
    end

    assign w_out = {1'b0, n_tmo, n_ack, n_rx, w_done, (n_phase != PH_IDLE),
                    n_sda_en, n_sda, n_scl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks    <= PHASE_TICKS_RESET;
            r_ack_poll_limit <= ACK_POLL_LIMIT_RESET;
            r_phase          <= PH_IDLE;
            r_delay          <= '0;
            r_poll           <= '0;
            r_bits           <= '0;
            r_shift          <= '0;
            r_scl            <= 1'b1;
            r_sda            <= 1'b1;
            r_sda_en         <= 1'b0;
            r_rx             <= '0;
            r_ack            <= 1'b0;
            r_tmo            <= 1'b0;
            r_ack_req        <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.index)
                    CFG_PHASE_TICKS:    r_phase_ticks    <= i_cfg.wdata;
                    CFG_ACK_POLL_LIMIT: r_ack_poll_limit <= i_cfg.wdata;
                    default:            r_phase_ticks    <= r_phase_ticks;
                endcase
            end
            if (w_step) begin
                r_phase   <= n_phase;
                r_delay   <= n_delay;
                r_poll    <= n_poll;
                r_bits    <= n_bits;
                r_shift   <= n_shift;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_sda_en  <= n_sda_en;
                r_rx      <= n_rx;
                r_ack     <= n_ack;
                r_tmo     <= n_tmo;
                r_ack_req <= n_ack_req;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_step) begin
            r_out_data <= w_out;
        end
    end

endmodule

[hdl/i2c_master_bit_engine.sv]
// Path: a tick request's result passes the front register at acceptance, then
// the queue, then the sequencer output register.
// Throughput: one tick per clock cycle while the output is not held off, one
// sequencer step per tick; the queue lets input and output stall separately.
// Reset: synchronous, active low; sequencer idle with SCL and SDA released high,
// phase_ticks back to 4 and ack_poll_limit back to 1000.
module i2c_master_bit_engine #(
    parameter int P_QUEUE_DEPTH = i2cm_pkg::I2CM_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: index 0 phase_ticks, index 1 ack_poll_limit.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // Tick requests in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] tx_byte, [8] ack_flag, [9] sda_in, rest zero
    input  logic [2:0]  s_axis_tuser,  // [0] cmd_valid, [2:1] operation
    // Line state out, one item per tick request.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] cmd_done,
    // [12:5] rx_byte, [13] ack_ok, [14] timed_out, [15] zero
    output logic [15:0] m_axis_tdata
);
    import i2cm_pkg::*;

    t_item   w_front_item;
    t_item   w_queue_item;
    logic    w_push;
    logic    w_queue_ready;
    logic    w_queue_valid;
    logic    w_pop;
    t_cfg_wr w_cfg;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.wdata = i_cfg_wdata;

    // The front stage takes requests whenever its register is free or the queue
    // can take its current item, so it keeps accepting while results wait.
    i2cm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (w_push),
        .o_item        (w_front_item),
        .i_queue_ready (w_queue_ready)
    );

    // The queue decouples the front stage from the sequencer.
    i2cm_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_queue_ready),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item),
        .i_pop   (w_pop)
    );

    // The sequencer steps once per request, whenever its output register is
    // empty or being drained in the same cycle.
    i2cm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_item_valid  (w_queue_valid),
        .i_item        (w_queue_item),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[bench/testbench.sv]
// Self-checking bench for the I2C master line sequencer: tick requests checked against a line-state predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cm_pkg::*;

    // The run stops here even if the block hangs. A correct run sends about
    // seven hundred requests.
    localparam int CYCLE_LIMIT = 200_000;
    // Three register stages between a request and its result, plus margin.
    localparam int PIPE_SETTLE = 8;
    // Length of the deliberate receiver hold-off, long enough to fill the queue.
    localparam int LONG_HOLD   = 200;
    // Mismatch lines printed before reporting goes quiet. Counting goes on.
    localparam int MAX_REPORTS = 40;
    // Minimum number of random requests sent per configuration round.
    localparam int ROUND_TICKS = 20;

    // Sequencer phases as the predictor tracks them.
    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_START_A, SEQ_START_B, SEQ_START_C, SEQ_START_D,
        SEQ_STOP_A, SEQ_STOP_B, SEQ_STOP_C, SEQ_STOP_D,
        SEQ_WR_LOW, SEQ_WR_HIGH,
        SEQ_ACK_A, SEQ_ACK_B, SEQ_ACK_C, SEQ_ACK_POLL, SEQ_ACK_D,
        SEQ_RD_A, SEQ_RD_HIGH, SEQ_RD_LOW,
        SEQ_MACK_A, SEQ_MACK_B, SEQ_MACK_C, SEQ_MACK_D
    } seq_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] tx_byte, [8] ack_flag, [9] sda_in, [15:10] zero
    logic [2:0]  s_axis_tuser;   // [0] cmd_valid, [2:1] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] cmd_done,
    // [12:5] rx_byte, [13] ack_ok, [14] timed_out, [15] zero
    logic [15:0] m_axis_tdata;

    i2c_master_bit_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predicted line state, one copy of everything the sequencer keeps.
    seq_t        line_seq;
    logic [15:0] line_delay;
    logic [15:0] line_poll;
    logic [3:0]  line_bits;
    logic [7:0]  line_shift;
    logic [7:0]  line_rx;
    logic        line_scl;
    logic        line_sda;
    logic        line_drive;
    logic        line_ack;
    logic        line_tmo;
    logic        line_ackreq;
    logic        line_done;
    // Predicted configuration registers.
    logic [15:0] cfg_ticks;
    logic [15:0] cfg_poll;

    // Expected line-state words, oldest first.
    logic [15:0] line_expect_q[$];

    // Stimulus shaping: the byte a slave returns on reads and the chance, in
    // percent, that it pulls SDA low on each acknowledge poll.
    logic [7:0]  rd_pattern;
    int          ack_pct;
    // When low, neither side inserts random gaps.
    logic        gaps_on;
    // A test raises this to ask the receiver for one long hold-off.
    logic        rx_hold_req;
    int          rx_stall = 0;
    int          err_count;
    int          cycle_count = 0;
    int          ticks_sent = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d results outstanding",
                     $time, line_expect_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Gap lengths shared by both sides: mostly none, often short, now and then
    // a long one.
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver side. A requested long hold-off takes priority over the random
    // stalls, so the queue inside the block fills and its input stalls.
    always @(posedge i_clk) begin : rx_side
        int hold_len;
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_stall = LONG_HOLD;
        end
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            hold_len = pick_gap();
            m_axis_tready <= (hold_len == 0);
            if (hold_len > 0)
                rx_stall = hold_len - 1;
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    // Every accepted result is matched against the oldest expectation.
    always @(posedge i_clk) begin : line_checker
        logic [15:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (line_expect_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
            end else begin
                want = line_expect_q.pop_front();
                check_field("scl_out",   want[0],    m_axis_tdata[0]);
                check_field("sda_out",   want[1],    m_axis_tdata[1]);
                check_field("sda_drive", want[2],    m_axis_tdata[2]);
                check_field("busy_res",  want[3],    m_axis_tdata[3]);
                check_field("cmd_done",  want[4],    m_axis_tdata[4]);
                check_field("rx_byte",   want[12:5], m_axis_tdata[12:5]);
                check_field("ack_ok",    want[13],   m_axis_tdata[13]);
                check_field("timed_out", want[14],   m_axis_tdata[14]);
            end
        end
    end

    // Enter a phase and hold it for the configured number of ticks.
    // A zero register counts as one tick.
    function automatic void hold_line(input seq_t nxt);
        line_seq = nxt;
        line_delay = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
    endfunction

    function automatic void end_command();
        line_seq = SEQ_IDLE;
        line_delay = 16'd0;
        line_done = 1'b1;
    endfunction

    // Advance the predicted sequencer by one tick and return the line-state
    // word that the block should report for it.
    function automatic logic [15:0] predict_tick(input logic cmd_v, input t_op op,
                                                 input logic [7:0] tx, input logic ackf,
                                                 input logic sda);
        line_done = 1'b0;
        if (line_seq == SEQ_IDLE) begin
            // A command is taken only while idle; its first line setting shows
            // on the accepting tick.
            if (cmd_v) begin
                case (op)
                    OP_START: begin
                        line_drive = 1'b1;
                        line_scl = 1'b1;
                        hold_line(SEQ_START_A);
                    end
                    OP_STOP: begin
                        line_drive = 1'b1;
                        line_sda = 1'b0;
                        hold_line(SEQ_STOP_A);
                    end
                    OP_WRITE: begin
                        // A write clears both status flags when it starts.
                        line_drive = 1'b1;
                        line_scl = 1'b0;
                        line_shift = tx;
                        line_bits = 4'd0;
                        line_ackreq = ackf;
                        line_sda = tx[7];
                        line_ack = 1'b0;
                        line_tmo = 1'b0;
                        hold_line(SEQ_WR_LOW);
                    end
                    default: begin
                        line_drive = 1'b0;
                        line_scl = 1'b0;
                        line_shift = 8'd0;
                        line_bits = 4'd0;
                        line_ackreq = ackf;
                        hold_line(SEQ_RD_A);
                    end
                endcase
            end
        end else if (line_seq == SEQ_ACK_POLL) begin
            // One poll per tick; a low SDA is the acknowledge. When the limit
            // runs out, the write gives up and a stop sequence follows.
            if (!sda) begin
                line_scl = 1'b0;
                hold_line(SEQ_ACK_D);
            end else begin
                if (line_poll != 16'd0)
                    line_poll--;
                if (line_poll == 16'd0) begin
                    line_tmo = 1'b1;
                    line_ack = 1'b0;
                    line_drive = 1'b1;
                    line_sda = 1'b0;
                    hold_line(SEQ_STOP_A);
                end
            end
        end else if (line_delay <= 16'd1) begin
            case (line_seq)
                SEQ_START_A: begin line_sda = 1'b1; hold_line(SEQ_START_B); end
                SEQ_START_B: begin line_sda = 1'b0; hold_line(SEQ_START_C); end
                SEQ_START_C: begin line_scl = 1'b0; hold_line(SEQ_START_D); end
                SEQ_STOP_A:  begin line_scl = 1'b0; hold_line(SEQ_STOP_B); end
                SEQ_STOP_B:  begin line_scl = 1'b1; hold_line(SEQ_STOP_C); end
                SEQ_STOP_C:  begin line_sda = 1'b1; hold_line(SEQ_STOP_D); end
                SEQ_WR_LOW:  begin line_scl = 1'b1; hold_line(SEQ_WR_HIGH); end
                SEQ_WR_HIGH: begin
                    line_scl = 1'b0;
                    line_bits = line_bits + 4'd1;
                    line_shift = line_shift << 1;
                    if (line_bits < BITS_PER_BYTE) begin
                        line_sda = line_shift[7];
                        hold_line(SEQ_WR_LOW);
                    end else if (line_ackreq) begin
                        line_drive = 1'b0;
                        hold_line(SEQ_ACK_A);
                    end else begin
                        // No acknowledge awaited counts as acknowledged.
                        line_ack = 1'b1;
                        end_command();
                    end
                end
                SEQ_ACK_A: begin line_sda = 1'b1; hold_line(SEQ_ACK_B); end
                SEQ_ACK_B: begin line_scl = 1'b1; hold_line(SEQ_ACK_C); end
                SEQ_ACK_C: begin
                    // Polling starts on the tick after the SCL-high hold.
                    line_poll = (cfg_poll == 16'd0) ? 16'd1 : cfg_poll;
                    line_seq = SEQ_ACK_POLL;
                    line_delay = 16'd0;
                end
                SEQ_ACK_D: begin line_ack = 1'b1; end_command(); end
                SEQ_RD_A:  begin line_scl = 1'b1; hold_line(SEQ_RD_HIGH); end
                SEQ_RD_HIGH: begin
                    line_shift = {line_shift[6:0], sda};
                    line_bits = line_bits + 4'd1;
                    line_scl = 1'b0;
                    hold_line(SEQ_RD_LOW);
                end
                SEQ_RD_LOW: begin
                    if (line_bits < BITS_PER_BYTE) begin
                        line_scl = 1'b1;
                        hold_line(SEQ_RD_HIGH);
                    end else begin
                        line_rx = line_shift;
                        line_scl = 1'b0;
                        hold_line(SEQ_MACK_A);
                    end
                end
                SEQ_MACK_A: begin
                    line_drive = 1'b1;
                    line_sda = line_ackreq ? 1'b0 : 1'b1;
                    hold_line(SEQ_MACK_B);
                end
                SEQ_MACK_B: begin line_scl = 1'b1; hold_line(SEQ_MACK_C); end
                SEQ_MACK_C: begin line_scl = 1'b0; hold_line(SEQ_MACK_D); end
                default: end_command();
            endcase
        end else begin
            line_delay--;
        end
        return {1'b0, line_tmo, line_ack, line_rx, line_done, (line_seq != SEQ_IDLE),
                line_drive, line_sda, line_scl};
    endfunction

    // The SDA level a slave would present: the planned read byte while SCL is
    // high in a read, a biased choice during acknowledge polling, noise elsewhere.
    function automatic logic pick_sda();
        if (line_seq == SEQ_RD_HIGH)
            return rd_pattern[7 - line_bits];
        if (line_seq == SEQ_ACK_POLL)
            return ($urandom_range(0, 99) >= ack_pct);
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one tick request after an optional gap and predict its result once
    // it is accepted. The valid stays high afterwards unless the next call
    // opens a gap, so it never drops and rises within one time step.
    task automatic send_tick(input logic cmd_v, input t_op op, input logic [7:0] tx,
                             input logic ackf, input logic sda);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {op, cmd_v};
        s_axis_tdata <= {6'd0, sda, ackf, tx};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        line_expect_q.push_back(predict_tick(cmd_v, op, tx, ackf, sda));
        ticks_sent++;
    endtask

    // A tick while a command runs: any command it carries must be ignored.
    task automatic busy_tick();
        send_tick(1'($urandom_range(0, 1)), t_op'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_sda());
    endtask

    task automatic idle_tick();
        send_tick(1'b0, t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Issue one command from idle and keep ticking until it has finished.
    task automatic run_command(input t_op op, input logic [7:0] tx, input logic ackf);
        send_tick(1'b1, op, tx, ackf, pick_sda());
        while (line_seq != SEQ_IDLE)
            busy_tick();
    endtask

    // Let the sequencer go idle, stop offering, and wait for every result.
    task automatic settle();
        while (line_seq != SEQ_IDLE)
            busy_tick();
        s_axis_tvalid <= 1'b0;
        while (line_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // Register writes happen only after settle(). The trailing edge keeps two
    // back-to-back writes from touching the enable twice in one time step.
    task automatic cfg_write(input logic idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PHASE_TICKS)
            cfg_ticks = val;
        else
            cfg_poll = val;
        @(posedge i_clk);
    endtask

    // Reset values of the registers: four-tick phases, and a write that is
    // acknowledged well inside the 1000-poll limit.
    task automatic test_reset_defaults();
        send_tick(1'b0, OP_START, 8'h00, 1'b0, 1'b0);
        send_tick(1'b0, OP_READ, 8'hFF, 1'b1, 1'b1);
        run_command(OP_START, 8'h00, 1'b0);
        ack_pct = 100;
        run_command(OP_WRITE, 8'hFF, 1'b1);
        rd_pattern = 8'hFF;
        run_command(OP_READ, 8'h00, 1'b1);
        run_command(OP_STOP, 8'h00, 1'b0);
        settle();
    endtask

    // One-tick phases and a one-poll limit: the tightest legal timing.
    task automatic test_fastest_timing();
        cfg_write(CFG_PHASE_TICKS, 16'd1);
        cfg_write(CFG_ACK_POLL_LIMIT, 16'd1);
        ack_pct = 0;
        run_command(OP_WRITE, 8'hA5, 1'b1);
        rd_pattern = 8'hA5;
        run_command(OP_READ, 8'h00, 1'b1);
        // Start and stop must leave the timeout status standing.
        run_command(OP_START, 8'hFF, 1'b1);
        run_command(OP_STOP, 8'h00, 1'b0);
        ack_pct = 100;
        run_command(OP_WRITE, 8'h3C, 1'b1);
        settle();
    endtask

    // Zero in either register behaves as one.
    task automatic test_zero_registers();
        cfg_write(CFG_PHASE_TICKS, 16'd0);
        cfg_write(CFG_ACK_POLL_LIMIT, 16'd0);
        ack_pct = 0;
        run_command(OP_WRITE, 8'hC3, 1'b1);
        rd_pattern = 8'h96;
        run_command(OP_READ, 8'h00, 1'b0);
        settle();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block has to stall its input; then the sender pauses until every
    // result is in before going on.
    task automatic test_backpressure();
        cfg_write(CFG_PHASE_TICKS, 16'd1);
        cfg_write(CFG_ACK_POLL_LIMIT, 16'd3);
        ack_pct = 40;
        rx_hold_req = 1'b1;
        run_command(OP_WRITE, 8'($urandom_range(0, 255)), 1'b1);
        rd_pattern = 8'($urandom_range(0, 255));
        run_command(OP_READ, 8'h00, 1'($urandom_range(0, 1)));
        settle();
        run_command(OP_START, 8'h00, 1'b0);
        run_command(OP_WRITE, 8'($urandom_range(0, 255)), 1'b0);
        settle();
    endtask

    // Random command streams under several timing settings. One round runs
    // with no gaps at all.
    task automatic test_random_traffic();
        int round_start;
        for (int r = 0; r < 6; r++) begin
            cfg_write(CFG_PHASE_TICKS, (r == 0) ? 16'd1 : 16'($urandom_range(1, 4)));
            cfg_write(CFG_ACK_POLL_LIMIT, (r == 1) ? 16'd1 : 16'($urandom_range(1, 6)));
            ack_pct = $urandom_range(10, 90);
            gaps_on = (r != 2);
            round_start = ticks_sent;
            while (ticks_sent - round_start < ROUND_TICKS) begin
                if ($urandom_range(0, 9) == 0) begin
                    idle_tick();
                end else begin
                    rd_pattern = 8'($urandom_range(0, 255));
                    run_command(t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)));
                end
            end
            settle();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_PHASE_TICKS;
        i_cfg_wdata <= 16'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 16'd0;
        s_axis_tuser <= 3'd0;
        m_axis_tready <= 1'b0;
        // Predictor starts from the reset state of the block.
        line_seq = SEQ_IDLE;
        line_delay = 16'd0;
        line_poll = 16'd0;
        line_bits = 4'd0;
        line_shift = 8'd0;
        line_rx = 8'd0;
        line_scl = 1'b1;
        line_sda = 1'b1;
        line_drive = 1'b0;
        line_ack = 1'b0;
        line_tmo = 1'b0;
        line_ackreq = 1'b0;
        line_done = 1'b0;
        cfg_ticks = PHASE_TICKS_RESET;
        cfg_poll = ACK_POLL_LIMIT_RESET;
        rd_pattern = 8'h00;
        ack_pct = 50;
        gaps_on = 1'b1;
        rx_hold_req = 1'b0;
        err_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_fastest_timing();
        test_zero_registers();
        test_backpressure();
        test_random_traffic();

        if (line_expect_q.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
